// ----- design/contiguous_list_engine_top_assert.svh -----
// Assertion macros for the contiguous list engine.
// CLE_ASSERT checks a property on every rising clock edge outside reset.
// CLE_ASSERT_NEXT checks that the consequent holds in the cycle after the antecedent.
`ifndef CONTIGUOUS_LIST_ENGINE_TOP_ASSERT_SVH
`define CONTIGUOUS_LIST_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CLE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");
`define CLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define CLE_ASSERT(lbl, clk, rstn, prop)
`define CLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- design/cle_pkg.sv -----
`default_nettype none

package cle_pkg;

  // Storage defaults
  localparam int CLE_DEPTH      = 64;
  localparam int CLE_DATA_WIDTH = 32;

  // Field widths
  localparam int REQ_W = 4;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int ST_W  = 3;
  localparam int CNT_W = 7;
  localparam int CAP_W = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND        = 4'd0,
    REQ_APPEND_UNIQUE = 4'd1,
    REQ_INSERT_FRONT  = 4'd2,
    REQ_READ          = 4'd3,
    REQ_WRITE         = 4'd4,
    REQ_REMOVE_LAST   = 4'd5,
    REQ_REMOVE_FIRST  = 4'd6,
    REQ_REMOVE_AT     = 4'd7,
    REQ_INSERT_AT     = 4'd8
  } req_type_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_BAD_POS = 3'd2,
    ST_DUP     = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SHIFT,
    S_DONE
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic eval;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_req;
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- design/cle_req_if.sv -----
`default_nettype none

interface cle_req_if import cle_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, req_type, position, value, input ready);
  modport sink   (input valid, req_type, position, value, output ready);
endinterface

`default_nettype wire

// ----- design/cle_rsp_if.sv -----
`default_nettype none

interface cle_rsp_if import cle_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] read_value;
  logic [ST_W-1:0]         status;
  logic [CNT_W-1:0]        count;

  modport source (output valid, read_value, status, count, input ready);
  modport sink   (input valid, read_value, status, count, output ready);
endinterface

`default_nettype wire

// ----- design/cle_cfg_if.sv -----
`default_nettype none

interface cle_cfg_if import cle_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

`default_nettype wire

// ----- design/cle_ram.sv -----
`default_nettype none

module cle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- design/cle_ctrl.sv -----
`default_nettype none

module cle_ctrl import cle_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire dp_sts_t sts_i,
  output ctrl_cmd_t    cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.scan_req ? S_SHIFT : S_DONE;
      end
      S_SHIFT: begin
        cmd_o.step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/cle_datapath.sv -----
`default_nettype none

module cle_datapath import cle_pkg::*; #(
  parameter int DEPTH      = CLE_DEPTH,
  parameter int DATA_WIDTH = CLE_DATA_WIDTH
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire ctrl_cmd_t               cmd_i,
  output dp_sts_t                      sts_o,
  input  wire logic [REQ_W-1:0]        req_type_i,
  input  wire logic [POS_W-1:0]        position_i,
  input  wire logic signed [VAL_W-1:0] value_i,
  input  wire logic                    cfg_valid_i,
  input  wire logic [CAP_W-1:0]        capacity_i,
  output logic                         rsp_valid_o,
  input  wire logic                    rsp_ready_i,
  output logic signed [VAL_W-1:0]      read_value_o,
  output logic [ST_W-1:0]              status_o,
  output logic [CNT_W-1:0]             count_o
);

  localparam int AW = $clog2(DEPTH);

  // Request registers
  req_type_e               req_q;
  logic [POS_W-1:0]        pos_q;
  logic signed [VAL_W-1:0] val_q;

  // List state
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CAP_W-1:0] cap_q;

  // Scan state
  logic [CNT_W-1:0] ptr_q, rem_q, lw_q;
  logic             lv_q, dn_q, cmp_q, dup_q;

  // Result register
  logic signed [VAL_W-1:0] rd_q;
  logic [ST_W-1:0]         st_q;
  logic [CNT_W-1:0]        oc_q;
  logic                    ov_q;

  // Memory port signals
  logic                  mem_re, mem_we;
  logic [AW-1:0]         mem_raddr, mem_waddr;
  logic [DATA_WIDTH-1:0] mem_rdata, mem_wdata;

  logic [DATA_WIDTH-1:0] word_w;
  logic signed [VAL_W-1:0] rd_word;
  logic             full, pos_bad, pos_bad_ins, empty, ok;
  status_e          base_st, fin_st;
  logic [CNT_W-1:0] ins_pos, rm_pos, shift_idx;
  logic [CNT_W-1:0] ptr_init, rem_init;
  logic             dn_init, cmp_init, scan_req;

  cle_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Stored word and widened read word
  assign word_w  = DATA_WIDTH'(val_q);
  assign rd_word = VAL_W'($signed(mem_rdata));

  // List conditions
  assign full        = (cnt_q >= cap_q) || (int'(cnt_q) >= DEPTH);
  assign pos_bad     = pos_q >= cnt_q;
  assign pos_bad_ins = pos_q > cnt_q;
  assign empty       = cnt_q == '0;

  // Decode status before any scan
  always_comb begin
    base_st = ST_OK;
    unique case (req_q) inside
      REQ_APPEND, REQ_APPEND_UNIQUE, REQ_INSERT_FRONT: begin
        if (full) base_st = ST_FULL;
      end
      REQ_READ, REQ_WRITE: begin
        if (pos_bad) base_st = ST_BAD_POS;
      end
      REQ_REMOVE_LAST, REQ_REMOVE_FIRST: begin
        if (empty) base_st = ST_EMPTY;
      end
      REQ_REMOVE_AT: begin
        if (empty) base_st = ST_EMPTY;
        else if (pos_bad) base_st = ST_BAD_POS;
      end
      REQ_INSERT_AT: begin
        if (full) base_st = ST_FULL;
        else if (pos_bad_ins) base_st = ST_BAD_POS;
      end
      default: base_st = ST_OK;
    endcase
  end

  assign ok     = base_st == ST_OK;
  assign fin_st = (ok && req_q == REQ_APPEND_UNIQUE && dup_q) ? ST_DUP : base_st;

  // Insert and remove points
  always_comb begin
    ins_pos = pos_q;
    rm_pos  = pos_q;
    unique case (req_q) inside
      REQ_APPEND, REQ_APPEND_UNIQUE: ins_pos = cnt_q;
      REQ_INSERT_FRONT:              ins_pos = '0;
      REQ_REMOVE_FIRST:              rm_pos  = '0;
      default:                       ins_pos = pos_q;
    endcase
  end

  // Scan setup: direction, compare mode, start and length
  always_comb begin
    dn_init  = 1'b0;
    cmp_init = 1'b0;
    ptr_init = '0;
    rem_init = '0;
    scan_req = 1'b0;
    unique case (req_q) inside
      REQ_INSERT_FRONT, REQ_INSERT_AT: begin
        dn_init  = 1'b1;
        ptr_init = cnt_q - 7'd1;
        rem_init = cnt_q - ins_pos;
        scan_req = ok;
      end
      REQ_APPEND_UNIQUE: begin
        cmp_init = 1'b1;
        rem_init = cnt_q;
        scan_req = ok;
      end
      REQ_REMOVE_FIRST, REQ_REMOVE_AT: begin
        ptr_init = rm_pos + 7'd1;
        rem_init = cnt_q - rm_pos - 7'd1;
        scan_req = ok;
      end
      default: scan_req = 1'b0;
    endcase
  end

  // Count after commit
  always_comb begin
    cnt_d = cnt_q;
    if (fin_st == ST_OK) begin
      unique case (req_q) inside
        REQ_APPEND, REQ_APPEND_UNIQUE, REQ_INSERT_FRONT, REQ_INSERT_AT:
          cnt_d = cnt_q + 7'd1;
        REQ_REMOVE_LAST, REQ_REMOVE_FIRST, REQ_REMOVE_AT:
          cnt_d = cnt_q - 7'd1;
        default: cnt_d = cnt_q;
      endcase
    end
  end

  // Target of a shifted entry
  assign shift_idx = dn_q ? (lw_q + 7'd1) : (lw_q - 7'd1);

  // Memory port steering
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = mem_rdata;
    if (cmd_i.eval && req_q == REQ_READ) begin
      mem_re    = 1'b1;
      mem_raddr = AW'(pos_q);
    end
    if (cmd_i.step) begin
      if (rem_q != '0) begin
        mem_re    = 1'b1;
        mem_raddr = AW'(ptr_q);
      end
      if (lv_q && !cmp_q) begin
        mem_we    = 1'b1;
        mem_waddr = AW'(shift_idx);
      end
    end
    if (cmd_i.commit && fin_st == ST_OK) begin
      unique case (req_q) inside
        REQ_APPEND, REQ_APPEND_UNIQUE, REQ_INSERT_FRONT, REQ_INSERT_AT: begin
          mem_we    = 1'b1;
          mem_waddr = AW'(ins_pos);
          mem_wdata = word_w;
        end
        REQ_WRITE: begin
          mem_we    = 1'b1;
          mem_waddr = AW'(pos_q);
          mem_wdata = word_w;
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  // Control state: count, capacity, scan progress, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      cap_q <= CAP_RESET;
      rem_q <= '0;
      lv_q  <= 1'b0;
      dup_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= capacity_i;
      end
      if (cmd_i.eval) begin
        rem_q <= scan_req ? rem_init : '0;
        lv_q  <= 1'b0;
        dup_q <= 1'b0;
      end
      if (cmd_i.step) begin
        lv_q <= rem_q != '0;
        if (rem_q != '0) begin
          rem_q <= rem_q - 7'd1;
        end
        if (lv_q && cmp_q && mem_rdata == word_w) begin
          dup_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        cnt_q <= cnt_d;
        ov_q  <= 1'b1;
      end else if (ov_q && rsp_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Payload: request, scan addresses, result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_e'(req_type_i);
      pos_q <= position_i;
      val_q <= value_i;
    end
    if (cmd_i.eval) begin
      ptr_q <= ptr_init;
      dn_q  <= dn_init;
      cmp_q <= cmp_init;
    end
    if (cmd_i.step && rem_q != '0) begin
      ptr_q <= dn_q ? (ptr_q - 7'd1) : (ptr_q + 7'd1);
      lw_q  <= ptr_q;
    end
    if (cmd_i.commit) begin
      rd_q <= (req_q == REQ_READ && fin_st == ST_OK) ? rd_word : '0;
      st_q <= fin_st;
      oc_q <= cnt_d;
    end
  end

  assign sts_o.scan_req  = scan_req;
  assign sts_o.scan_done = rem_q == '0;
  assign sts_o.out_free  = !ov_q || rsp_ready_i;

  assign rsp_valid_o  = ov_q;
  assign read_value_o = rd_q;
  assign status_o     = st_q;
  assign count_o      = oc_q;

endmodule

`default_nettype wire

// ----- design/contiguous_list_engine_top.sv -----
// Flow: an accepted request is registered and evaluated, then committed to the result
//   register once it is free; inserts, front and positional removals and unique appends that
//   pass their checks first move or compare entries (up to the count) in the shift state,
//   one entry per cycle on the RAM ports. One request at a time: the next is taken only
//   after the result is committed and the engine is back in idle.
// Reset: count cleared, capacity set to 64, result register empty; store contents undefined.
`default_nettype none
`include "contiguous_list_engine_top_assert.svh"

module contiguous_list_engine_top import cle_pkg::*; #(
  parameter int DEPTH      = CLE_DEPTH,
  parameter int DATA_WIDTH = CLE_DATA_WIDTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cle_cfg_if.sink   cfg_i,
  cle_req_if.sink   req_i,
  cle_rsp_if.source rsp_o
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  logic      in_ready;

  // Capacity writes are always taken
  assign cfg_i.ready = 1'b1;
  assign req_i.ready = in_ready;

  cle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cle_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_type_i   (req_i.req_type),
    .position_i   (req_i.position),
    .value_i      (req_i.value),
    .cfg_valid_i  (cfg_i.valid),
    .capacity_i   (cfg_i.capacity),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .read_value_o (rsp_o.read_value),
    .status_o     (rsp_o.status),
    .count_o      (rsp_o.count)
  );

  // Commit only into a free result register, and the result shows next cycle
  `CLE_ASSERT(a_commit_free, clk_i, rst_ni, cmd.commit |-> sts.out_free)
  `CLE_ASSERT_NEXT(a_commit_rsp, clk_i, rst_ni, cmd.commit, rsp_o.valid)
  // Hold off new requests while one is in flight
  `CLE_ASSERT_NEXT(a_busy_after_load, clk_i, rst_ni, req_i.valid && req_i.ready, !req_i.ready)
  // Reported count never exceeds the store depth
  `CLE_ASSERT(a_count_bound, clk_i, rst_ni, rsp_o.valid |-> (int'(rsp_o.count) <= DEPTH))

endmodule

`default_nettype wire
